### rtl/rdx_pkg.sv
// Package for the fixed-depth radix tree: operation codes, controller states
// and the request and response item types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdx_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_LEAF,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]      op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ValW-1:0] result_value;
    logic            found;
    logic            pool_full;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/fixed_depth_radix_tree.sv
// Fixed-depth radix tree with insert, lookup and delete requests.
// Depends on rdx_pkg (item types, op codes, states) and rdx_mem (node store).
//
// Usage: a request item (op, key, value) enters on the in channel when
// in_valid_i is high and in_stall_o is low; exactly one response item
// (result_value, found, pool_full) leaves on the out channel per request.
// The key is cut into LEVELS fields of LEVEL_BITS bits, top field first,
// and each field indexes one node of the tree held in a single node store.
// Requests are handled one at a time. Each tree level takes one registered
// read of the node store, for a lookup and for an insert or delete on an
// existing path; the leaf write of an insert or delete takes the place of
// the last read. An insert that builds new nodes spends one allocation step
// on each node that it links, and a lookup or delete on a missing path ends
// early. An undefined op goes straight to its response. The next request is
// taken once the response has moved into the output register. After reset
// the node store's NODES * 2^LEVEL_BITS entries are swept to zero at one
// entry per cycle, and no request is taken until the sweep ends. A finished
// response sits in an output register, so the next request is taken while
// the receiver stalls; a second response waits inside the block until that
// register empties.
`timescale 1ns / 1ps
`default_nettype none

module fixed_depth_radix_tree #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned LEVELS     = 4,
  parameter int unsigned LEVEL_BITS = 8,
  parameter int unsigned NODES      = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire rdx_pkg::req_t in_item_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output rdx_pkg::rsp_t     out_item_o
);

  import rdx_pkg::*;

  localparam int unsigned NodeW   = $clog2(NODES);
  localparam int unsigned AddrW   = NodeW + LEVEL_BITS;
  localparam int unsigned Depth   = NODES * (2 ** LEVEL_BITS);
  localparam int unsigned EntryW  = (VALUE_BITS > NodeW) ? VALUE_BITS : NodeW;
  localparam int unsigned LvlW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned NfW     = $clog2(NODES + 1);
  localparam int unsigned SumW    = ((NfW > LvlW) ? NfW : LvlW) + 1;
  localparam int unsigned ExtW    = KeyW + LEVELS * LEVEL_BITS;
  localparam int unsigned ValUse  = (VALUE_BITS < ValW) ? VALUE_BITS : ValW;
  localparam logic [KeyW-1:0] KeyMask = (KEY_BITS >= KeyW) ? {KeyW{1'b1}} :
                                        KeyW'((64'd1 << KEY_BITS) - 64'd1);

  function automatic logic [LEVEL_BITS-1:0] lvl_idx(input logic [KeyW-1:0] k,
                                                    input logic [LvlW-1:0] l);
    logic [ExtW-1:0] ext;
    ext = ExtW'(k & KeyMask);
    ext = ext >> (l * LEVEL_BITS);
    return ext[LEVEL_BITS-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ValW-1:0]   val_q, val_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic [LvlW-1:0]   lvl_q, lvl_d;
  logic              alloc_q, alloc_d;
  logic [NfW-1:0]    nf_q, nf_d;
  rsp_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic [AddrW-1:0]  rd_addr;
  logic [EntryW-1:0] rd_data;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [EntryW-1:0] wr_data;
  logic              mem_ready;

  logic              accept;
  logic              child_ok;
  logic [NodeW-1:0]  child;
  logic              pool_short;
  logic              out_free;
  logic [SumW-1:0]   need_sum;

  rdx_mem #(
    .ADDR_W(AddrW),
    .DATA_W(EntryW),
    .DEPTH (Depth)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .ready_o  (mem_ready)
  );

  assign in_stall_o = !((state_q == ST_IDLE) && mem_ready);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // A child number outside the pool counts as a missing node.
  assign child_ok   = (rd_data != '0) && ((65)'(rd_data) < (65)'(NODES));
  assign child      = rd_data[NodeW-1:0];
  assign need_sum   = SumW'(nf_q) + SumW'(lvl_q);
  assign pool_short = need_sum > SumW'(NODES);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.op != OP_INSERT && in_item_i.op != OP_LOOKUP &&
              in_item_i.op != OP_DELETE) begin
            state_d = ST_DONE;
          end else if (LEVELS == 1 && in_item_i.op != OP_LOOKUP) begin
            state_d = ST_LEAF;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (lvl_q == '0) begin
          state_d = ST_DONE;
        end else if (child_ok) begin
          if (lvl_q == LvlW'(1) && op_q != OP_LOOKUP) begin
            state_d = ST_LEAF;
          end
        end else if (op_q == OP_INSERT && !pool_short) begin
          state_d = ST_ALLOC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ALLOC: begin
        if (lvl_q == LvlW'(1)) begin
          state_d = ST_LEAF;
        end
      end
      ST_LEAF: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and node store controls.
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    node_d      = node_q;
    lvl_d       = lvl_q;
    alloc_d     = alloc_q;
    nf_d        = nf_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = {node_q, lvl_idx(key_q, lvl_q)};
    wr_en       = 1'b0;
    wr_addr     = {node_q, lvl_idx(key_q, lvl_q)};
    wr_data     = '0;
    unique case (state_q)
      ST_IDLE: begin
        // The root read is issued in the cycle the request is taken.
        rd_addr = {NodeW'(0), lvl_idx(in_item_i.key, LvlW'(LEVELS - 1))};
        if (accept) begin
          op_d    = in_item_i.op;
          key_d   = in_item_i.key;
          val_d   = in_item_i.value;
          node_d  = '0;
          lvl_d   = LvlW'(LEVELS - 1);
          alloc_d = 1'b0;
          res_d   = '0;
        end
      end
      ST_WALK: begin
        if (lvl_q == '0) begin
          res_d.result_value = ValW'(rd_data);
          res_d.found        = 1'b1;
        end else if (child_ok) begin
          // Follow the child at once: its entry is read in this same cycle.
          node_d  = child;
          lvl_d   = lvl_q - LvlW'(1);
          rd_addr = {child, lvl_idx(key_q, lvl_q - LvlW'(1))};
        end else if (op_q == OP_INSERT) begin
          res_d.pool_full = pool_short;
        end
      end
      ST_ALLOC: begin
        // Fresh nodes were zeroed by the reset sweep and never written since.
        wr_en   = 1'b1;
        wr_data = EntryW'(nf_q);
        node_d  = nf_q[NodeW-1:0];
        nf_d    = nf_q + NfW'(1);
        lvl_d   = lvl_q - LvlW'(1);
        alloc_d = 1'b1;
      end
      ST_LEAF: begin
        wr_en       = 1'b1;
        wr_addr     = {node_q, lvl_idx(key_q, LvlW'(0))};
        wr_data     = (op_q == OP_INSERT) ? EntryW'(val_q[ValUse-1:0]) : '0;
        res_d.found = !alloc_q;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nf_q        <= NfW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nf_q        <= nf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    val_q   <= val_d;
    node_q  <= node_d;
    lvl_q   <= lvl_d;
    alloc_q <= alloc_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_nf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= NfW'(NODES))
    else $error("free node counter ran past the pool");

  a_nf_only_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nf_q != $past(nf_q)) |-> ($past(state_q) == ST_ALLOC))
    else $error("free node counter moved outside node allocation");

  a_alloc_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALLOC) |-> (op_q == OP_INSERT))
    else $error("node allocation for a request that is not an insert");

  a_leaf_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEAF) |-> (op_q == OP_INSERT || op_q == OP_DELETE))
    else $error("leaf write for a lookup");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mem_ready |-> (in_stall_o && state_q == ST_IDLE))
    else $error("request activity while the node store is being cleared");

endmodule

`default_nettype wire

### rtl/rdx_mem.sv
// Node store of the radix tree: single-port-write, registered-read memory
// with a clearing sweep after reset. Does not depend on rdx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdx_mem #(
  parameter int unsigned ADDR_W = 14,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 16384
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  output logic                   ready_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [DATA_W-1:0] wd;

  // The sweep zeroes one entry per cycle until the last address is written.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we = clr_busy_q | wr_en_i;
  assign wa = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wd = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  assign ready_o = !clr_busy_q;

endmodule

`default_nettype wire

### tb/fixed_depth_radix_tree_test.sv
// Self-checking testbench for fixed_depth_radix_tree: drives insert, lookup,
// delete and reserved-op items and checks every response against a tree model kept here.
// Depends on rdx_pkg and the fixed_depth_radix_tree RTL.
`timescale 1ns / 1ps

module fixed_depth_radix_tree_test;
  import rdx_pkg::*;

  localparam int unsigned Levels     = 4;
  localparam int unsigned LevelBits  = 8;
  localparam int unsigned Nodes      = 64;
  localparam int unsigned Fan        = 1 << LevelBits;
  localparam int unsigned RandItems  = 1000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned MaxReports = 10;
  localparam logic [1:0]  OpReserved = 2'd3;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  req_t  in_item_i;
  logic  out_valid_o;
  logic  out_stall_i;
  rsp_t  out_item_o;

  bit calm;
  bit long_hold;

  class radix_scoreboard;
    bit [31:0]   tree_mem [Nodes*Fan];
    int unsigned free_node = 1;
    rsp_t        pending_q[$];
    int unsigned err_count;

    function int unsigned slot(int unsigned node, logic [31:0] key, int lvl);
      return node * Fan + ((key >> (lvl * LevelBits)) & (Fan - 1));
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    // Walks the tree as it stands before the item and applies its effect.
    function void note_request(req_t req);
      rsp_t        rsp;
      int unsigned node;
      int unsigned gap;
      int unsigned child;
      int          lvl;
      int unsigned i;
      rsp  = '0;
      node = 0;
      gap  = 0;
      if (req.op != OpReserved) begin
        for (lvl = Levels - 1; lvl >= 1 && gap == 0; lvl--) begin
          child = tree_mem[slot(node, req.key, lvl)];
          if (child == 0 || child >= Nodes) gap = lvl;
          else node = child;
        end
        if (req.op == OP_INSERT) begin
          if (gap > 0 && (free_node >= Nodes || gap > Nodes - free_node)) begin
            rsp.pool_full = 1'b1;
          end else begin
            rsp.found = (gap == 0);
            for (lvl = gap; lvl >= 1; lvl--) begin
              for (i = 0; i < Fan; i++) tree_mem[free_node * Fan + i] = '0;
              tree_mem[slot(node, req.key, lvl)] = free_node;
              node = free_node;
              free_node++;
            end
            tree_mem[slot(node, req.key, 0)] = req.value;
          end
        end else if (gap == 0) begin
          rsp.found = 1'b1;
          if (req.op == OP_LOOKUP) rsp.result_value = tree_mem[slot(node, req.key, 0)];
          else tree_mem[slot(node, req.key, 0)] = '0;
        end
      end
      pending_q.push_back(rsp);
    endfunction

    function void report(string what, rsp_t want, rsp_t got);
      err_count++;
      if (err_count <= MaxReports)
        $display("%0t %s: expected value=%h found=%0d pool_full=%0d, got value=%h found=%0d pool_full=%0d",
                 $time, what, want.result_value, want.found, want.pool_full,
                 got.result_value, got.found, got.pool_full);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_q.size() == 0) begin
        report("response with no request pending", '0, got);
      end else begin
        want = pending_q.pop_front();
        if (got.result_value !== want.result_value || got.found !== want.found ||
            got.pool_full !== want.pool_full)
          report("response mismatch", want, got);
      end
    endfunction
  endclass

  radix_scoreboard sb;

  fixed_depth_radix_tree #(
    .KEY_BITS  (32),
    .LEVELS    (Levels),
    .LEVEL_BITS(LevelBits),
    .NODES     (Nodes),
    .VALUE_BITS(32)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("[fixed_depth_radix_tree] ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_response(out_item_o);
      if (in_valid_i && !in_stall_o) sb.note_request(in_item_i);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
    end
  end

  task automatic send_request(req_t req);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i  = req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_op(logic [1:0] op, logic [31:0] key, logic [31:0] value);
    req_t req;
    req.op    = op;
    req.key   = key;
    req.value = value;
    send_request(req);
  endtask

  task automatic sender_gap(int unsigned cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_field(int unsigned choices);
    case ($urandom_range(0, choices - 1))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h5A;
      3:       return 8'h81;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Most keys come from a few shared prefixes so that paths get reused and
  // the node pool lasts; the rest are raw noise that eventually drains it.
  function automatic req_t random_request();
    req_t        req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       req.value = '0;
      1:       req.value = '1;
      default: req.value = $urandom;
    endcase
    if (pick < 10) begin
      req.key = $urandom;
      req.op  = 2'($urandom_range(0, 3));
    end else begin
      req.key = {pick_field(3), pick_field(2), pick_field(3), pick_field(5)};
      if (pick < 45) req.op = OP_INSERT;
      else if (pick < 80) req.op = OP_LOOKUP;
      else req.op = OP_DELETE;
    end
    return req;
  endfunction

  initial begin
    int unsigned n;
    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    calm       = 1'b0;
    long_hold  = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // The block sweeps its node store after reset and holds off input until
    // then, so the first item simply waits on the handshake.
    send_op(OP_LOOKUP, 32'h0000_0000, 32'h0);
    send_op(OP_DELETE, 32'h0000_0000, 32'h0);
    send_op(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(OP_LOOKUP, 32'h0000_0000, 32'h0);
    send_op(OP_INSERT, 32'h0000_0000, 32'h0000_0001);
    send_op(OP_LOOKUP, 32'h0000_0001, 32'h0);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_INSERT, 32'h0000_00FF, 32'hA5A5_A5A5);
    send_op(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(OP_LOOKUP, 32'h0000_0000, 32'h0);
    send_op(OP_DELETE, 32'h0000_FF00, 32'h0);
    send_op(OP_INSERT, 32'h00FF_0000, 32'h5A5A_5A5A);
    send_op(OpReserved, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OpReserved, 32'h0000_0000, 32'h0);
    send_op(OP_LOOKUP, 32'h00FF_0000, 32'h0);
    send_op(OP_INSERT, 32'h0000_FF00, 32'h1234_5678);
    send_op(OP_LOOKUP, 32'h0000_00FF, 32'h0);
    send_op(OP_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    wait_idle();

    for (n = 0; n < RandItems; n++) begin
      calm = (n >= 600 && n < 700) || n >= 900;
      if (n == 300) long_hold = 1'b1;
      if (n == 500) wait_idle();
      if (!calm && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 19));
      send_request(random_request());
    end

    wait_idle();
    repeat (32) @(negedge clk_i);
    if (sb.err_count == 0 && sb.pending() == 0) begin
      $display("[fixed_depth_radix_tree] OK");
    end else begin
      $display("[fixed_depth_radix_tree] ERROR");
    end
    $finish;
  end

endmodule
